// ===== rtl/core/wtvs_pkg.sv =====
// ============================================================================
// wtvs_pkg
// Shared widths, register indexes and types of the weighted total variation
// sum block.
// ============================================================================
package wtvs_pkg;

    // store geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_DEPTH   = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = 16;
    localparam int X_W         = 8;
    localparam int Y_W         = 8;
    localparam int Z_W         = 12;
    localparam int STORE_W     = 32;

    // field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int DIM_W    = 9;
    localparam int DEPTH_W  = 13;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;
    localparam int SQ_W     = 34;
    localparam int ROOT_W   = 17;
    localparam int PROD_W   = 33;
    localparam int SUM_W    = 63;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEPTH  = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 2;

    // one classified voxel word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0]        weight;
        logic [X_W-1:0]             x;
        logic [Y_W-1:0]             y;
        logic                       has_a;   // previous-slice term
        logic                       has_b;   // upper-row term
        logic                       has_c;   // left term in last row
        logic                       x_in;    // right neighbour inside
        logic                       y_in;    // lower neighbour inside
        logic                       last;    // last voxel of volume
    } entry_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } q_status_t;

endpackage

// ===== rtl/core/wtvs_ram.sv =====
// ============================================================================
// wtvs_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module wtvs_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/core/wtvs_front.sv =====
// ============================================================================
// wtvs_front
// Holds the dimension registers and voxel counters, tags each accepted
// word with the terms it completes.
// ============================================================================
module wtvs_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wtvs_pkg::IDX_W-1:0]            cfg_index,
    input  logic [wtvs_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  push,
    input  logic signed [wtvs_pkg::SAMPLE_W-1:0]  sample,
    input  logic [wtvs_pkg::WEIGHT_W-1:0]         weight,
    output wtvs_pkg::entry_t                      entry
);

    logic [wtvs_pkg::DIM_W-1:0]   w_reg, h_reg;
    logic [wtvs_pkg::DEPTH_W-1:0] d_reg;
    logic [wtvs_pkg::X_W-1:0]     x_reg;
    logic [wtvs_pkg::Y_W-1:0]     y_reg;
    logic [wtvs_pkg::Z_W-1:0]     z_reg;
    logic [wtvs_pkg::DIM_W-1:0]   x_plus, y_plus, w_val, h_val;
    logic [wtvs_pkg::DEPTH_W-1:0] z_plus, d_val;
    logic                         row_end, col_last, last_slice;

    // clamped register values
    always_comb
    begin
        w_val = cfg_data[wtvs_pkg::DIM_W-1:0];
        if (w_val == '0)
            w_val = wtvs_pkg::DIM_W'(1);
        else if (w_val > wtvs_pkg::DIM_W'(wtvs_pkg::MAX_WIDTH))
            w_val = wtvs_pkg::DIM_W'(wtvs_pkg::MAX_WIDTH);
        h_val = cfg_data[wtvs_pkg::DIM_W-1:0];
        if (h_val == '0)
            h_val = wtvs_pkg::DIM_W'(1);
        else if (h_val > wtvs_pkg::DIM_W'(wtvs_pkg::MAX_HEIGHT))
            h_val = wtvs_pkg::DIM_W'(wtvs_pkg::MAX_HEIGHT);
        d_val = cfg_data[wtvs_pkg::DEPTH_W-1:0];
        if (d_val == '0)
            d_val = wtvs_pkg::DEPTH_W'(1);
        else if (d_val > wtvs_pkg::DEPTH_W'(wtvs_pkg::MAX_DEPTH))
            d_val = wtvs_pkg::DEPTH_W'(wtvs_pkg::MAX_DEPTH);
    end

    // position classification
    assign x_plus     = {1'b0, x_reg} + wtvs_pkg::DIM_W'(1);
    assign y_plus     = {1'b0, y_reg} + wtvs_pkg::DIM_W'(1);
    assign z_plus     = {1'b0, z_reg} + wtvs_pkg::DEPTH_W'(1);
    assign row_end    = x_plus >= w_reg;
    assign col_last   = y_plus >= h_reg;
    assign last_slice = z_plus >= d_reg;

    always_comb
    begin
        entry.sample = sample;
        entry.weight = weight;
        entry.x      = x_reg;
        entry.y      = y_reg;
        entry.has_a  = z_reg != '0;
        entry.has_b  = last_slice && (y_reg != '0);
        entry.has_c  = last_slice && col_last && (x_reg != '0);
        entry.x_in   = !row_end;
        entry.y_in   = !col_last;
        entry.last   = row_end && col_last && last_slice;
    end

    // registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= wtvs_pkg::DIM_W'(wtvs_pkg::MAX_WIDTH);
            h_reg <= wtvs_pkg::DIM_W'(wtvs_pkg::MAX_HEIGHT);
            d_reg <= wtvs_pkg::DEPTH_W'(1);
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wtvs_pkg::REG_WIDTH:  w_reg <= w_val;
                wtvs_pkg::REG_HEIGHT: h_reg <= h_val;
                wtvs_pkg::REG_DEPTH:  d_reg <= d_val;
                default: ;
            endcase
            if (cfg_index == wtvs_pkg::REG_WIDTH || cfg_index == wtvs_pkg::REG_HEIGHT ||
                cfg_index == wtvs_pkg::REG_DEPTH)
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
            end
        end
        else if (push)
        begin
            if (entry.last)
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
            end
            else if (row_end)
            begin
                x_reg <= '0;
                if (col_last)
                begin
                    y_reg <= '0;
                    z_reg <= z_plus[wtvs_pkg::Z_W-1:0];
                end
                else
                begin
                    y_reg <= y_plus[wtvs_pkg::Y_W-1:0];
                end
            end
            else
            begin
                x_reg <= x_plus[wtvs_pkg::X_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/core/wtvs_queue.sv =====
// ============================================================================
// wtvs_queue
// Two-entry queue of classified words between front and back.
// ============================================================================
module wtvs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wtvs_pkg::entry_t     push_entry,
    input  logic                 pop,
    output wtvs_pkg::entry_t     head,
    output wtvs_pkg::q_status_t  status
);

    wtvs_pkg::entry_t mem_reg [wtvs_pkg::QDEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'(wtvs_pkg::QDEPTH);
    assign status.empty = count_reg == 2'd0;
    assign status.count = count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/core/wtvs_back.sv =====
// ============================================================================
// wtvs_back
// Sequencer that reads the slice store, forms each term with a bit-pair
// square root and one multiply, accumulates and delivers the sum.
// ============================================================================
module wtvs_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  wtvs_pkg::entry_t                 head,
    input  logic                             q_empty,
    output logic                             pop,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [wtvs_pkg::SUM_W-1:0]       tv_sum
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NEXT  = 4'd1;
    localparam logic [3:0] ST_ISSUE = 4'd2;
    localparam logic [3:0] ST_CAPC  = 4'd3;
    localparam logic [3:0] ST_CAP1  = 4'd4;
    localparam logic [3:0] ST_CAP2  = 4'd5;
    localparam logic [3:0] ST_OWN   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;

    localparam logic [2:0] PH_A     = 3'd0;
    localparam logic [2:0] PH_WRITE = 3'd1;
    localparam logic [2:0] PH_B     = 3'd2;
    localparam logic [2:0] PH_C     = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [1:0] TERM_A = 2'd0;
    localparam logic [1:0] TERM_B = 2'd1;
    localparam logic [1:0] TERM_C = 2'd2;

    logic [3:0]                         state_reg;
    logic [2:0]                         phase_reg;
    logic [1:0]                         term_reg;
    wtvs_pkg::entry_t                   ent_reg;
    logic signed [wtvs_pkg::SAMPLE_W-1:0] ctr_s_reg;
    logic [wtvs_pkg::WEIGHT_W-1:0]      ctr_w_reg;
    logic [wtvs_pkg::SQ_W-1:0]          sumsq_reg, n_reg, res_reg, bit_reg;
    logic [wtvs_pkg::PROD_W-1:0]        prod_reg;
    logic [wtvs_pkg::SUM_W-1:0]         acc_reg, out_sum_reg;
    logic                               out_valid_reg;

    logic [wtvs_pkg::ADDR_W-1:0]        here, ctr_addr, n1_addr, n2_addr, rd_addr;
    logic                               n1_en, n2_en, ram_we, out_load;
    logic [wtvs_pkg::STORE_W-1:0]       rd_data;
    logic signed [wtvs_pkg::SAMPLE_W-1:0] rd_s, other_s;
    logic signed [wtvs_pkg::SAMPLE_W:0] diff;
    logic [wtvs_pkg::SAMPLE_W:0]        diff_abs;
    logic [2*wtvs_pkg::SAMPLE_W-1:0]    sq;
    logic [wtvs_pkg::SQ_W-1:0]          trial;
    logic [wtvs_pkg::SUM_W:0]           acc_sum;

    // neighbour addresses of the current term
    assign here = {ent_reg.y, ent_reg.x};
    always_comb
    begin
        ctr_addr = here;
        n1_addr  = {ent_reg.y, ent_reg.x + 8'd1};
        n2_addr  = {ent_reg.y + 8'd1, ent_reg.x};
        n1_en    = 1'b0;
        n2_en    = 1'b0;
        unique case (term_reg)
            TERM_A:
            begin
                n1_en = ent_reg.x_in;
                n2_en = ent_reg.y_in;
            end
            TERM_B:
            begin
                ctr_addr = {ent_reg.y - 8'd1, ent_reg.x};
                n1_addr  = {ent_reg.y - 8'd1, ent_reg.x + 8'd1};
                n1_en    = ent_reg.x_in;
            end
            TERM_C:
            begin
                ctr_addr = {ent_reg.y, ent_reg.x - 8'd1};
            end
            default: ;
        endcase
    end

    // read address per step
    always_comb
    begin
        case (state_reg)
            ST_CAPC: rd_addr = n1_addr;
            ST_CAP1: rd_addr = n2_addr;
            default: rd_addr = ctr_addr;
        endcase
    end

    assign ram_we = (state_reg == ST_NEXT) && (phase_reg == PH_WRITE);

    wtvs_ram #(
        .DATA_W (wtvs_pkg::STORE_W),
        .DEPTH  (wtvs_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (here),
        .wdata ({ent_reg.sample, ent_reg.weight}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // shared difference squarer
    assign rd_s     = rd_data[wtvs_pkg::STORE_W-1:wtvs_pkg::WEIGHT_W];
    assign other_s  = (state_reg == ST_OWN) ? ent_reg.sample : rd_s;
    assign diff     = {ctr_s_reg[wtvs_pkg::SAMPLE_W-1], ctr_s_reg}
                    - {other_s[wtvs_pkg::SAMPLE_W-1], other_s};
    assign diff_abs = diff[wtvs_pkg::SAMPLE_W] ? -diff : diff;
    assign sq       = diff_abs[wtvs_pkg::SAMPLE_W-1:0] * diff_abs[wtvs_pkg::SAMPLE_W-1:0];

    // square root step and accumulate
    assign trial   = res_reg + bit_reg;
    assign acc_sum = {1'b0, acc_reg} + (wtvs_pkg::SUM_W+1)'(prod_reg);

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_load = (state_reg == ST_NEXT) && (phase_reg == PH_DONE) && ent_reg.last
                    && (!out_valid_reg || !result_stall);

    assign result_valid = out_valid_reg;
    assign tv_sum       = out_sum_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= head;
        if (state_reg == ST_CAPC)
        begin
            ctr_s_reg <= rd_s;
            ctr_w_reg <= rd_data[wtvs_pkg::WEIGHT_W-1:0];
            sumsq_reg <= '0;
        end
        if (state_reg == ST_CAP1 && n1_en)
            sumsq_reg <= sumsq_reg + wtvs_pkg::SQ_W'(sq);
        if (state_reg == ST_CAP2 && n2_en)
            sumsq_reg <= sumsq_reg + wtvs_pkg::SQ_W'(sq);
        if (state_reg == ST_OWN)
        begin
            n_reg   <= sumsq_reg + wtvs_pkg::SQ_W'(sq);
            res_reg <= '0;
            bit_reg <= wtvs_pkg::SQ_W'(64'd1 << 32);
        end
        if (state_reg == ST_SQRT)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == ST_MUL)
            prod_reg <= ctr_w_reg * res_reg[wtvs_pkg::ROOT_W-1:0];
        if (out_load)
            out_sum_reg <= acc_reg;
    end

    // sequencer, accumulator and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_A;
            term_reg      <= TERM_A;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;

            if (clear)
                acc_reg <= '0;
            else if (state_reg == ST_ACC)
                acc_reg <= acc_sum[wtvs_pkg::SUM_W] ? '1 : acc_sum[wtvs_pkg::SUM_W-1:0];
            else if (out_load)
                acc_reg <= '0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        phase_reg <= PH_A;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    unique case (phase_reg)
                        PH_A:
                        begin
                            phase_reg <= PH_WRITE;
                            if (ent_reg.has_a)
                            begin
                                term_reg  <= TERM_A;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        PH_WRITE: phase_reg <= PH_B;
                        PH_B:
                        begin
                            phase_reg <= PH_C;
                            if (ent_reg.has_b)
                            begin
                                term_reg  <= TERM_B;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        PH_C:
                        begin
                            phase_reg <= PH_DONE;
                            if (ent_reg.has_c)
                            begin
                                term_reg  <= TERM_C;
                                state_reg <= ST_ISSUE;
                            end
                        end
                        PH_DONE:
                        begin
                            if (!ent_reg.last || out_load)
                                state_reg <= ST_IDLE;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_ISSUE: state_reg <= ST_CAPC;
                ST_CAPC:  state_reg <= ST_CAP1;
                ST_CAP1:  state_reg <= ST_CAP2;
                ST_CAP2:  state_reg <= ST_OWN;
                ST_OWN:   state_reg <= ST_SQRT;
                ST_SQRT:
                begin
                    if (bit_reg[0])
                        state_reg <= ST_MUL;
                end
                ST_MUL:   state_reg <= ST_ACC;
                ST_ACC:   state_reg <= ST_NEXT;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/weighted_total_variation_sum.sv =====
// ============================================================================
// weighted_total_variation_sum
// Weighted isotropic total variation of an image or volume streamed in
// raster order.
// ============================================================================
// Usage: voxel words (sample, weight) enter on sample_valid / sample_stall,
// x fastest, then rows, then slices. After the last voxel of a volume one
// word carrying tv_sum leaves on result_valid / result_stall.
// Dimensions are to be written through cfg_write / cfg_index / cfg_data only
// while the block is idle, which the block itself does not enforce; a write
// restarts the volume and clears the sum. In the back end each word forms the
// terms it completes (0 to 3): every term costs three store reads through
// the single read port of the slice store, a 17-step square root loop and a
// multiply and accumulate. A two-word queue lets the front accept up to two
// words ahead of the back end.
// The sum is loaded into an output register as the last word leaves the back
// end and waits there while result_stall is high; the last word of a later
// volume holds the back end until it is taken, and the queue then fills and
// raises sample_stall. Reset clears counters, sum and queue and sets the
// dimensions to 256 x 256 x 1; the slice store is not cleared.
// ============================================================================
module weighted_total_variation_sum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [wtvs_pkg::IDX_W-1:0]           cfg_index,
    input  logic [wtvs_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [wtvs_pkg::SAMPLE_W-1:0] sample,
    input  logic [wtvs_pkg::WEIGHT_W-1:0]        weight,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [wtvs_pkg::SUM_W-1:0]           tv_sum
);

    wtvs_pkg::entry_t    front_entry, q_head;
    wtvs_pkg::q_status_t q_stat;
    logic                q_push, q_pop;
    logic                cfg_hit;

    assign sample_stall = q_stat.full;
    assign q_push       = sample_valid && !q_stat.full;

    // only writes to an existing register restart the sum
    assign cfg_hit = cfg_write && (cfg_index == wtvs_pkg::REG_WIDTH ||
                                   cfg_index == wtvs_pkg::REG_HEIGHT ||
                                   cfg_index == wtvs_pkg::REG_DEPTH);

    // front: counters and classification
    wtvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (q_push),
        .sample    (sample),
        .weight    (weight),
        .entry     (front_entry)
    );

    // queue between the two halves
    wtvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_stat)
    );

    // back: store access and arithmetic
    wtvs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_hit),
        .head         (q_head),
        .q_empty      (q_stat.empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .tv_sum       (tv_sum)
    );

    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("queue written while full");

    // back end never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // fill level rises on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 2'd1))
        else $error("queue level lost a word");

endmodule
